@@ sv/bpra_pkg.sv @@
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// bpra_pkg: shared types and constants of the page run allocator
// codes for actions, status and configuration registers, fsm and op types
// ---------------------------------------------------------------------------
package bpra_pkg;

  // default geometry
  localparam int unsigned POOL_PAGES_DEF    = 4096;
  localparam int unsigned MAP_WORD_BITS_DEF = 64;

  // field widths
  localparam int unsigned ACTION_W = 2;
  localparam int unsigned FRAME_W  = 52;
  localparam int unsigned COUNT_W  = 13;
  localparam int unsigned PBASE_W  = 40;
  localparam int unsigned STATUS_W = 2;
  localparam int unsigned CFG_W    = 52;
  localparam int unsigned CFG_IDX_W = 2;

  // action codes
  localparam logic [ACTION_W-1:0] ACT_ALLOC      = 2'd0;
  localparam logic [ACTION_W-1:0] ACT_FREE       = 2'd1;
  localparam logic [ACTION_W-1:0] ACT_POOL_RESET = 2'd2;

  // status codes
  localparam logic [STATUS_W-1:0] STAT_OK    = 2'd0;
  localparam logic [STATUS_W-1:0] STAT_NO_RUN = 2'd1;
  localparam logic [STATUS_W-1:0] STAT_BELOW = 2'd2;
  localparam logic [STATUS_W-1:0] STAT_ZERO  = 2'd3;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_POOL_BASE  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_POOL_COUNT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_DMAP_BASE  = 2'd2;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_FREE_SUB,
    S_FREE_CHK,
    S_FREE_CLIP,
    S_MARK,
    S_DONE
  } state_e;

  // what the marking sweep does to each word
  typedef enum logic [1:0] {
    OP_ALLOC,
    OP_FREE,
    OP_FILL,
    OP_WIPE
  } op_e;

endpackage

@@ sv/bitmap_page_run_allocator_unit.sv @@
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// bitmap_page_run_allocator_unit: first-fit contiguous page run allocator
// free bitmap of the pool in one ram, word-wise run scan and marking sweep
// ---------------------------------------------------------------------------
//
//  channel   direction  handshake                payload
//  --------  ---------  -----------------------  ---------------------------------
//  request   in         in_valid_i / in_ready_o  action_i, virt_frame_i, page_count_i
//  result    out        out_valid_o / out_ready_i status_o, first_frame_o
//  config    in         cfg_we_i (no wait)       cfg_index_i, cfg_data_i
//
//  one request at a time; the bitmap ram gives one word per cycle, which sets the pace
//  allocate: scan words until a run fits, then sweep its words to mark them
//  free: subtract, check, clip, sweep from word 0 to the run end; pool reset: all words
//  after reset a clearing pass writes all MAP_WORDS words before the first request
//  a result waits in the output register; the next request is taken meanwhile
// ---------------------------------------------------------------------------
module bitmap_page_run_allocator_unit #(
  parameter int unsigned POOL_PAGES    = bpra_pkg::POOL_PAGES_DEF,
  parameter int unsigned MAP_WORD_BITS = bpra_pkg::MAP_WORD_BITS_DEF
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  // request channel
  input  logic                              in_valid_i,
  output logic                              in_ready_o,
  input  logic [bpra_pkg::ACTION_W-1:0]     action_i,
  input  logic [bpra_pkg::FRAME_W-1:0]      virt_frame_i,
  input  logic [bpra_pkg::COUNT_W-1:0]      page_count_i,
  // result channel
  output logic                              out_valid_o,
  input  logic                              out_ready_i,
  output logic [bpra_pkg::STATUS_W-1:0]     status_o,
  output logic [bpra_pkg::FRAME_W-1:0]      first_frame_o,
  // configuration
  input  logic                              cfg_we_i,
  input  logic [bpra_pkg::CFG_IDX_W-1:0]    cfg_index_i,
  input  logic [bpra_pkg::CFG_W-1:0]        cfg_data_i
);

  localparam int unsigned W   = MAP_WORD_BITS;
  localparam int unsigned MW  = (POOL_PAGES + MAP_WORD_BITS - 1) / MAP_WORD_BITS;
  localparam int unsigned AW  = (MW > 1) ? $clog2(MW) : 1;
  localparam int unsigned PW  = $clog2(MW * MAP_WORD_BITS + 1);
  localparam int unsigned CW  = ((PW > bpra_pkg::COUNT_W) ? PW : bpra_pkg::COUNT_W) + 1;
  localparam int unsigned NW  = $clog2(MAP_WORD_BITS + 1);
  localparam int unsigned BW  = $clog2(MAP_WORD_BITS);
  localparam int unsigned FW  = bpra_pkg::FRAME_W;
  localparam int unsigned EW  = bpra_pkg::FRAME_W + 1;
  localparam logic [AW-1:0] LAST_WORD = AW'(MW - 1);

  // configuration registers
  logic [bpra_pkg::PBASE_W-1:0] pbase_q;
  logic [bpra_pkg::COUNT_W-1:0] pcount_q;
  logic [FW-1:0]                dmap_q;
  logic [FW-1:0]                base_sum_q;

  // control
  bpra_pkg::state_e state_q, state_d;
  bpra_pkg::op_e    op_q, op_d;
  logic [AW-1:0]    wi_q, wi_d;        // word being scanned or marked
  logic [PW-1:0]    wb_q, wb_d;        // page index of its bit 0
  logic             out_valid_q, out_valid_d;

  // request payload and working values
  logic [FW-1:0]                 vframe_q, vframe_d;
  logic [bpra_pkg::COUNT_W-1:0]  count_q, count_d;
  logic [bpra_pkg::STATUS_W-1:0] stat_q, stat_d;
  logic                          alloc_ok_q, alloc_ok_d;
  logic [FW-1:0]                 phys_q, phys_d;
  logic [PW-1:0]                 run_q, run_d;
  logic [PW-1:0]                 rs_p_q, rs_p_d;   // run start page
  logic [AW-1:0]                 rs_w_q, rs_w_d;   // run start word
  logic [PW-1:0]                 rs_b_q, rs_b_d;   // base of run start word
  logic [PW-1:0]                 lo_q, lo_d;       // marked pages lo .. hi-1
  logic [PW-1:0]                 hi_q, hi_d;
  logic [bpra_pkg::STATUS_W-1:0] out_status_q, out_status_d;
  logic [FW-1:0]                 out_frame_q, out_frame_d;

  // bitmap ram
  logic          ram_we;
  logic [AW-1:0] ram_waddr;
  logic [W-1:0]  ram_wdata;
  logic          ram_re;
  logic [AW-1:0] ram_raddr;
  logic [W-1:0]  ram_rdata;

  // word analysis
  logic [NW-1:0] tail_ones;
  logic [NW-1:0] head_ones;
  logic          all_ones;
  logic          in_hit;
  logic [BW-1:0] in_pos;

  // derived values
  logic [CW-1:0] lim_c;
  logic [PW-1:0] lim;
  logic [CW-1:0] run_sum;
  logic          fits_word;
  logic          hit_tail;
  logic          found;
  logic [PW-1:0] start_p;
  logic [AW-1:0] start_w;
  logic [PW-1:0] start_b;
  logic [CW-1:0] start_end;
  logic [PW-1:0] lo_diff;
  logic [PW-1:0] hi_diff;
  logic [NW-1:0] lo_rel;
  logic [NW-1:0] hi_rel;
  logic [W-1:0]  mask;
  logic          mark_last;
  logic [EW-1:0] chk_diff;
  logic [EW-1:0] free_end;
  logic          off_big;

  bpra_ram #(
    .WIDTH (W),
    .DEPTH (MW)
  ) u_map_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  bpra_scan #(
    .WORD_BITS (W)
  ) u_scan (
    .word_i      (ram_rdata),
    .count_i     (count_q[NW-1:0]),
    .tail_ones_o (tail_ones),
    .head_ones_o (head_ones),
    .all_ones_o  (all_ones),
    .hit_o       (in_hit),
    .hit_pos_o   (in_pos)
  );

  // pool limit, clipped to POOL_PAGES
  assign lim_c = (CW'(pcount_q) > CW'(POOL_PAGES)) ? CW'(POOL_PAGES) : CW'(pcount_q);
  assign lim   = lim_c[PW-1:0];

  // scan step: does the run through this word reach count, or does a run of count bits fit inside it
  assign run_sum   = CW'(run_q) + CW'(tail_ones);
  assign fits_word = CW'(count_q) <= CW'(W);
  assign hit_tail  = run_sum >= CW'(count_q);
  assign found     = hit_tail || (fits_word && in_hit);

  always_comb begin
    if (hit_tail && run_q != '0) begin
      // run started in an earlier word
      start_p = rs_p_q;
      start_w = rs_w_q;
      start_b = rs_b_q;
    end else if (hit_tail) begin
      start_p = wb_q;
      start_w = wi_q;
      start_b = wb_q;
    end else begin
      start_p = wb_q + PW'(in_pos);
      start_w = wi_q;
      start_b = wb_q;
    end
  end

  assign start_end = CW'(start_p) + CW'(count_q);

  // marking mask of the current word: bits lo_rel .. hi_rel-1
  assign lo_diff = lo_q - wb_q;
  assign hi_diff = hi_q - wb_q;

  always_comb begin
    lo_rel = '0;
    if (lo_q > wb_q) begin
      lo_rel = (lo_diff >= PW'(W)) ? NW'(W) : NW'(lo_diff);
    end
    hi_rel = '0;
    if (hi_q > wb_q) begin
      hi_rel = (hi_diff >= PW'(W)) ? NW'(W) : NW'(hi_diff);
    end
    for (int i = 0; i < W; i++) begin
      mask[i] = (NW'(i) < hi_rel) && !(NW'(i) < lo_rel);
    end
  end

  // free path: offset in the pool and clipped end
  assign chk_diff = EW'(phys_q) - EW'(pbase_q);
  assign off_big  = phys_q >= FW'(lim);
  assign free_end = EW'(phys_q) + EW'(count_q);

  // sweep ends at the last word, or for alloc and free once the next word lies past the range
  always_comb begin
    mark_last = (wi_q == LAST_WORD);
    if ((op_q == bpra_pkg::OP_ALLOC || op_q == bpra_pkg::OP_FREE) &&
        (CW'(wb_q) + CW'(W) >= CW'(hi_q))) begin
      mark_last = 1'b1;
    end
  end

  // fsm: next state, ram control, working registers
  always_comb begin
    state_d      = state_q;
    op_d         = op_q;
    wi_d         = wi_q;
    wb_d         = wb_q;
    out_valid_d  = out_valid_q;
    vframe_d     = vframe_q;
    count_d      = count_q;
    stat_d       = stat_q;
    alloc_ok_d   = alloc_ok_q;
    phys_d       = phys_q;
    run_d        = run_q;
    rs_p_d       = rs_p_q;
    rs_w_d       = rs_w_q;
    rs_b_d       = rs_b_q;
    lo_d         = lo_q;
    hi_d         = hi_q;
    out_status_d = out_status_q;
    out_frame_d  = out_frame_q;
    ram_we       = 1'b0;
    ram_waddr    = wi_q;
    ram_wdata    = '0;
    ram_re       = 1'b0;
    ram_raddr    = '0;

    // result register drains independently
    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end

    unique case (state_q)
      bpra_pkg::S_IDLE: begin
        // word 0 is fetched ahead for a possible scan
        ram_re = 1'b1;
        if (in_valid_i) begin
          vframe_d   = virt_frame_i;
          count_d    = page_count_i;
          stat_d     = bpra_pkg::STAT_OK;
          alloc_ok_d = 1'b0;
          wi_d       = '0;
          wb_d       = '0;
          run_d      = '0;
          if (action_i == bpra_pkg::ACT_ALLOC) begin
            op_d = bpra_pkg::OP_ALLOC;
            if (page_count_i == '0) begin
              stat_d  = bpra_pkg::STAT_ZERO;
              state_d = bpra_pkg::S_DONE;
            end else begin
              state_d = bpra_pkg::S_SCAN;
            end
          end else if (action_i == bpra_pkg::ACT_FREE) begin
            op_d = bpra_pkg::OP_FREE;
            if (page_count_i == '0) begin
              stat_d  = bpra_pkg::STAT_ZERO;
              state_d = bpra_pkg::S_DONE;
            end else begin
              state_d = bpra_pkg::S_FREE_SUB;
            end
          end else if (action_i == bpra_pkg::ACT_POOL_RESET) begin
            op_d    = bpra_pkg::OP_FILL;
            lo_d    = '0;
            hi_d    = lim;
            state_d = bpra_pkg::S_MARK;
          end else begin
            // unused action: plain ok result
            op_d    = bpra_pkg::OP_FILL;
            state_d = bpra_pkg::S_DONE;
          end
        end
      end

      bpra_pkg::S_SCAN: begin
        if (found) begin
          lo_d       = start_p;
          hi_d       = start_end[PW-1:0];
          wi_d       = start_w;
          wb_d       = start_b;
          alloc_ok_d = 1'b1;
          ram_re     = 1'b1;
          ram_raddr  = start_w;
          state_d    = bpra_pkg::S_MARK;
        end else if (wi_q == LAST_WORD) begin
          stat_d  = bpra_pkg::STAT_NO_RUN;
          state_d = bpra_pkg::S_DONE;
        end else begin
          // carry the free run into the next word
          if (all_ones) begin
            run_d = run_q + PW'(W);
            if (run_q == '0) begin
              rs_p_d = wb_q;
              rs_w_d = wi_q;
              rs_b_d = wb_q;
            end
          end else begin
            run_d  = PW'(head_ones);
            rs_p_d = wb_q + PW'(W) - PW'(head_ones);
            rs_w_d = wi_q;
            rs_b_d = wb_q;
          end
          wi_d      = wi_q + 1'b1;
          wb_d      = wb_q + PW'(W);
          ram_re    = 1'b1;
          ram_raddr = wi_q + 1'b1;
        end
      end

      bpra_pkg::S_FREE_SUB: begin
        phys_d  = vframe_q - dmap_q;
        state_d = bpra_pkg::S_FREE_CHK;
      end

      bpra_pkg::S_FREE_CHK: begin
        if (chk_diff[EW-1]) begin
          stat_d  = bpra_pkg::STAT_BELOW;
          state_d = bpra_pkg::S_DONE;
        end else begin
          phys_d  = chk_diff[FW-1:0];
          state_d = bpra_pkg::S_FREE_CLIP;
        end
      end

      bpra_pkg::S_FREE_CLIP: begin
        lo_d      = off_big ? lim : phys_q[PW-1:0];
        hi_d      = (off_big || free_end >= EW'(lim)) ? lim : free_end[PW-1:0];
        wi_d      = '0;
        wb_d      = '0;
        ram_re    = 1'b1;
        ram_raddr = '0;
        state_d   = bpra_pkg::S_MARK;
      end

      bpra_pkg::S_MARK: begin
        ram_we = 1'b1;
        unique case (op_q)
          bpra_pkg::OP_ALLOC: ram_wdata = ram_rdata & ~mask;
          bpra_pkg::OP_FREE:  ram_wdata = ram_rdata | mask;
          bpra_pkg::OP_FILL:  ram_wdata = mask;
          bpra_pkg::OP_WIPE:  ram_wdata = '0;
          default:            ram_wdata = '0;
        endcase
        if (mark_last) begin
          state_d = (op_q == bpra_pkg::OP_WIPE) ? bpra_pkg::S_IDLE : bpra_pkg::S_DONE;
        end else begin
          wi_d      = wi_q + 1'b1;
          wb_d      = wb_q + PW'(W);
          ram_re    = (op_q == bpra_pkg::OP_ALLOC || op_q == bpra_pkg::OP_FREE);
          ram_raddr = wi_q + 1'b1;
        end
      end

      bpra_pkg::S_DONE: begin
        if (!out_valid_q || out_ready_i) begin
          out_valid_d  = 1'b1;
          out_status_d = stat_q;
          out_frame_d  = alloc_ok_q ? (base_sum_q + FW'(lo_q)) : '0;
          state_d      = bpra_pkg::S_IDLE;
        end
      end

      default: begin
        state_d = bpra_pkg::S_IDLE;
      end
    endcase
  end

  // control registers; reset starts the clearing pass over the bitmap
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= bpra_pkg::S_MARK;
      op_q        <= bpra_pkg::OP_WIPE;
      wi_q        <= '0;
      wb_q        <= '0;
      out_valid_q <= 1'b0;
      pbase_q     <= '0;
      pcount_q    <= '0;
      dmap_q      <= '0;
    end else begin
      state_q     <= state_d;
      op_q        <= op_d;
      wi_q        <= wi_d;
      wb_q        <= wb_d;
      out_valid_q <= out_valid_d;
      if (cfg_we_i) begin
        unique case (cfg_index_i)
          bpra_pkg::CFG_POOL_BASE:  pbase_q  <= cfg_data_i[bpra_pkg::PBASE_W-1:0];
          bpra_pkg::CFG_POOL_COUNT: pcount_q <= cfg_data_i[bpra_pkg::COUNT_W-1:0];
          bpra_pkg::CFG_DMAP_BASE:  dmap_q   <= cfg_data_i;
          default: ;
        endcase
      end
    end
  end

  // payload and working registers
  always_ff @(posedge clk_i) begin
    base_sum_q   <= dmap_q + FW'(pbase_q);
    vframe_q     <= vframe_d;
    count_q      <= count_d;
    stat_q       <= stat_d;
    alloc_ok_q   <= alloc_ok_d;
    phys_q       <= phys_d;
    run_q        <= run_d;
    rs_p_q       <= rs_p_d;
    rs_w_q       <= rs_w_d;
    rs_b_q       <= rs_b_d;
    lo_q         <= lo_d;
    hi_q         <= hi_d;
    out_status_q <= out_status_d;
    out_frame_q  <= out_frame_d;
  end

  assign in_ready_o    = (state_q == bpra_pkg::S_IDLE);
  assign out_valid_o   = out_valid_q;
  assign status_o      = out_status_q;
  assign first_frame_o = out_frame_q;

  // one request in flight
  a_single_request: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("request accepted while another is in progress");

  // only a successful allocation carries a frame
  a_frame_only_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (status_o != bpra_pkg::STAT_OK) |-> first_frame_o == '0)
    else $error("nonzero frame on a failed request");

  // sweep never reads the word it writes
  a_ram_no_overlap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ram_we && ram_re |-> ram_waddr != ram_raddr)
    else $error("bitmap read and write hit the same word");

  // results come only from the done state
  a_result_source: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(state_q == bpra_pkg::S_DONE))
    else $error("result raised outside the done state");

endmodule

@@ sv/bpra_ram.sv @@
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// bpra_ram: generic simple dual port ram
// one write port, one read port, read data registered
// ---------------------------------------------------------------------------
module bpra_ram #(
  parameter int unsigned WIDTH = bpra_pkg::MAP_WORD_BITS_DEF,
  parameter int unsigned DEPTH = 64,
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

@@ sv/bpra_scan.sv @@
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// bpra_scan: free-run analysis of one bitmap word
// trailing and leading free runs, and the lowest run of count bits inside
// ---------------------------------------------------------------------------
module bpra_scan #(
  parameter int unsigned WORD_BITS = bpra_pkg::MAP_WORD_BITS_DEF,
  localparam int unsigned NW = $clog2(WORD_BITS + 1),
  localparam int unsigned BW = $clog2(WORD_BITS)
) (
  input  logic [WORD_BITS-1:0] word_i,
  input  logic [NW-1:0]        count_i,
  output logic [NW-1:0]        tail_ones_o,
  output logic [NW-1:0]        head_ones_o,
  output logic                 all_ones_o,
  output logic                 hit_o,
  output logic [BW-1:0]        hit_pos_o
);

  logic                 tail_seen;
  logic                 head_seen;
  logic                 pos_seen;
  logic                 acc_set;
  logic [WORD_BITS-1:0] acc;
  logic [WORD_BITS-1:0] pj;

  assign all_ones_o = &word_i;

  always_comb begin
    // first zero from the bottom
    tail_ones_o = NW'(WORD_BITS);
    tail_seen   = 1'b0;
    for (int i = 0; i < WORD_BITS; i++) begin
      if (!tail_seen && !word_i[i]) begin
        tail_ones_o = NW'(i);
        tail_seen   = 1'b1;
      end
    end
    // first zero from the top
    head_ones_o = NW'(WORD_BITS);
    head_seen   = 1'b0;
    for (int i = WORD_BITS - 1; i >= 0; i--) begin
      if (!head_seen && !word_i[i]) begin
        head_ones_o = NW'(WORD_BITS - 1 - i);
        head_seen   = 1'b1;
      end
    end
    // acc bit i: bits i .. i+count-1 all free, built by doubling
    // the first piece taken is the run itself, so runs touching the top bit count
    acc     = '0;
    acc_set = 1'b0;
    pj      = word_i;
    for (int j = 0; j < NW; j++) begin
      if (count_i[j]) begin
        acc     = acc_set ? (pj & (acc >> (1 << j))) : pj;
        acc_set = 1'b1;
      end
      pj = pj & (pj >> (1 << j));
    end
    hit_o     = (|acc) && (count_i != '0);
    hit_pos_o = '0;
    pos_seen  = 1'b0;
    for (int i = 0; i < WORD_BITS; i++) begin
      if (!pos_seen && acc[i]) begin
        hit_pos_o = BW'(i);
        pos_seen  = 1'b1;
      end
    end
  end

endmodule

@@ dv/tb.sv @@
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb: self-checking bench for bitmap_page_run_allocator_unit
// a shadow free map predicts every reply of the allocator; requests come from
// directed cases, register extremes and long runs of random alloc/free
// traffic under changing handshake stalls, and each reply is compared by field
// ---------------------------------------------------------------------------
module tb;
  import bpra_pkg::*;

  localparam int unsigned POOL_PAGES = POOL_PAGES_DEF;
  localparam int unsigned MAP_WORDS  = POOL_PAGES / MAP_WORD_BITS_DEF;
  // allocate scans and marks at most every word once; BUSY_MAX leaves room for overhead
  localparam int unsigned BUSY_MAX   = 2 * MAP_WORDS + 8;
  localparam int unsigned IDLE_PAD   = BUSY_MAX + 24;
  // longest quiet stretch: the long output hold plus one full request
  localparam int unsigned QUIET_MAX  = 4000;
  localparam int unsigned HOLD_LONG  = 400;
  localparam int unsigned PHASE_ITEMS = 365;
  localparam logic [ACTION_W-1:0] ACT_UNUSED = 2'd3;
  localparam logic [PBASE_W-1:0]  PBASE_MAX  = '1;
  localparam logic [FRAME_W-1:0]  FRAME_MAX  = '1;
  localparam logic [COUNT_W-1:0]  COUNT_MAX  = '1;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [FRAME_W-1:0]  frame;
  } page_reply_t;

  logic                clk_i;
  logic                rst_ni;
  logic                in_valid_i;
  logic                in_ready_o;
  logic [ACTION_W-1:0] action_i;
  logic [FRAME_W-1:0]  virt_frame_i;
  logic [COUNT_W-1:0]  page_count_i;
  logic                out_valid_o;
  logic                out_ready_i;
  logic [STATUS_W-1:0] status_o;
  logic [FRAME_W-1:0]  first_frame_o;
  logic                cfg_we_i;
  logic [CFG_IDX_W-1:0] cfg_index_i;
  logic [CFG_W-1:0]    cfg_data_i;

  // shadow copy of the allocator: bitmap and registers
  bit [POOL_PAGES-1:0] shadow_free;
  logic [PBASE_W-1:0]  sh_pool_base;
  logic [COUNT_W-1:0]  sh_pool_count;
  logic [FRAME_W-1:0]  sh_dmap_base;

  page_reply_t page_replies[$];
  page_reply_t last_reply;
  int unsigned mismatches;
  int unsigned quiet_cycles;

  // stall knobs shared with the output side
  int unsigned send_idle_pct;
  int unsigned recv_idle_pct;
  int unsigned hold_len;

  // runs handed out and not yet returned, for well-formed frees
  logic [FRAME_W-1:0] live_frame[$];
  logic [COUNT_W-1:0] live_count[$];

  bitmap_page_run_allocator_unit uut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .action_i     (action_i),
    .virt_frame_i (virt_frame_i),
    .page_count_i (page_count_i),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .status_o     (status_o),
    .first_frame_o(first_frame_o),
    .cfg_we_i     (cfg_we_i),
    .cfg_index_i  (cfg_index_i),
    .cfg_data_i   (cfg_data_i)
  );

  initial begin
    clk_i = 1'b0;
    rst_ni = 1'b0;
    in_valid_i = 1'b0;
    action_i = '0;
    virt_frame_i = '0;
    page_count_i = '0;
    cfg_we_i = 1'b0;
    cfg_index_i = '0;
    cfg_data_i = '0;
  end

  always #4 clk_i = ~clk_i;

  // ---------------------------------------------------------------------------
  // prediction
  // ---------------------------------------------------------------------------

  // usable pages; counts above the pool size act as the pool size
  function automatic int unsigned usable_pages();
    return (sh_pool_count > POOL_PAGES) ? POOL_PAGES : int'(sh_pool_count);
  endfunction

  // applies one request to the shadow map and returns the reply it must give
  function automatic page_reply_t page_action_result(input logic [ACTION_W-1:0] act,
                                                      input logic [FRAME_W-1:0] vf,
                                                      input logic [COUNT_W-1:0] cnt);
    page_reply_t r;
    int unsigned run;
    int unsigned start;
    bit found;
    logic [FRAME_W-1:0] phys;
    longint unsigned off;
    longint unsigned stop;
    longint unsigned lim;
    r.status = STAT_OK;
    r.frame = '0;
    lim = usable_pages();
    case (act)
      ACT_POOL_RESET: begin
        shadow_free = '0;
        for (int unsigned p = 0; p < lim; p++) shadow_free[p] = 1'b1;
      end
      ACT_ALLOC: begin
        if (cnt == 0) begin
          r.status = STAT_ZERO;
        end else begin
          // first fit: lowest run of cnt free pages, a used page restarts the run
          r.status = STAT_NO_RUN;
          run = 0;
          found = 1'b0;
          start = 0;
          for (int unsigned p = 0; p < POOL_PAGES; p++) begin
            if (shadow_free[p]) begin
              run++;
              if (run == cnt) begin
                start = p + 1 - cnt;
                found = 1'b1;
                break;
              end
            end else begin
              run = 0;
            end
          end
          if (found) begin
            for (int unsigned q = start; q < start + cnt; q++) shadow_free[q] = 1'b0;
            r.status = STAT_OK;
            r.frame = sh_dmap_base + FRAME_W'(sh_pool_base) + FRAME_W'(start);
          end
        end
      end
      ACT_FREE: begin
        phys = vf - sh_dmap_base;
        if (cnt == 0) begin
          r.status = STAT_ZERO;
        end else if (phys < FRAME_W'(sh_pool_base)) begin
          r.status = STAT_BELOW;
        end else begin
          // pages beyond the usable pool are left alone
          off = phys - FRAME_W'(sh_pool_base);
          stop = off + cnt;
          if (stop > lim) stop = lim;
          for (longint unsigned q = off; q < stop; q++) shadow_free[q] = 1'b1;
        end
      end
      default: ;
    endcase
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // drivers
  // ---------------------------------------------------------------------------

  // writes all three registers on back-to-back cycles; block must be idle
  task automatic apply_config(input logic [PBASE_W-1:0] pb, input logic [COUNT_W-1:0] pc,
                              input logic [FRAME_W-1:0] dm);
    @(negedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_index_i <= CFG_POOL_BASE;
    cfg_data_i <= CFG_W'(pb);
    sh_pool_base = pb;
    @(negedge clk_i);
    cfg_index_i <= CFG_POOL_COUNT;
    cfg_data_i <= CFG_W'(pc);
    sh_pool_count = pc;
    @(negedge clk_i);
    cfg_index_i <= CFG_DMAP_BASE;
    cfg_data_i <= CFG_W'(dm);
    sh_dmap_base = dm;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  // offers one request, waits for it to be taken and queues its predicted reply
  task automatic send_request(input logic [ACTION_W-1:0] act, input logic [FRAME_W-1:0] vf,
                              input logic [COUNT_W-1:0] cnt);
    @(negedge clk_i);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    action_i <= act;
    virt_frame_i <= vf;
    page_count_i <= cnt;
    do @(posedge clk_i); while (!in_ready_o);
    last_reply = page_action_result(act, vf, cnt);
    page_replies.push_back(last_reply);
  endtask

  // stops offering and waits until every reply is back
  task automatic drain_replies();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (page_replies.size() != 0) @(posedge clk_i);
  endtask

  // drained and then quiet long enough for the longest request to finish
  task automatic settle_block();
    drain_replies();
    repeat (IDLE_PAD) @(posedge clk_i);
  endtask

  function automatic logic [FRAME_W-1:0] rand_frame();
    return FRAME_W'({$urandom, $urandom});
  endfunction

  // ---------------------------------------------------------------------------
  // output side and checking
  // ---------------------------------------------------------------------------

  // ready at random, or held low for a stretch set by hold_len when asked
  initial begin
    out_ready_i = 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold_len != 0) begin
        out_ready_i <= 1'b0;
        repeat (hold_len - 1) @(negedge clk_i);
        hold_len = 0;
      end else begin
        out_ready_i <= ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  task automatic note_mismatch(input string what, input longint unsigned want,
                               input longint unsigned got);
    mismatches++;
    if (mismatches <= 10)
      $display("%0t mismatch %s: expected %0h got %0h", $realtime, what, want, got);
  endtask

  always @(posedge clk_i) begin
    page_reply_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (page_replies.size() == 0) begin
        note_mismatch("unexpected reply status", 0, status_o);
      end else begin
        want = page_replies.pop_front();
        if (status_o !== want.status) note_mismatch("status", want.status, status_o);
        if (first_frame_o !== want.frame) note_mismatch("first_frame", want.frame, first_frame_o);
      end
    end
  end

  // watchdog on cycles with no handshake on either channel
  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= QUIET_MAX) begin
      $display("timeout after %0d quiet cycles", quiet_cycles);
      $display("== FAIL ==");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // tests
  // ---------------------------------------------------------------------------

  // hand-picked requests: field extremes, every action and the corner cases
  task automatic test_directed_basics();
    logic [FRAME_W-1:0] pool0;
    logic [FRAME_W-1:0] f1;
    apply_config(40'h10_0000_1000, 13'd100, 52'h8_0000_0000_0);
    pool0 = sh_dmap_base + FRAME_W'(sh_pool_base);
    send_request(ACT_ALLOC, '0, 13'd1);               // nothing free yet
    send_request(ACT_POOL_RESET, '0, '0);
    send_request(ACT_ALLOC, '0, '0);                  // zero count
    send_request(ACT_ALLOC, FRAME_MAX, 13'd1);
    f1 = last_reply.frame;
    send_request(ACT_ALLOC, '0, 13'd64);
    send_request(ACT_ALLOC, '0, 13'd4096);            // longer than any run
    send_request(ACT_ALLOC, '0, COUNT_MAX);           // beyond the pool size
    send_request(ACT_FREE, f1, '0);                   // zero count free
    send_request(ACT_FREE, pool0 - 1, 13'd1);         // just below the pool
    send_request(ACT_FREE, f1, 13'd1);
    send_request(ACT_FREE, f1, 13'd1);                // double free
    send_request(ACT_FREE, pool0 + 100, 13'd5);       // entirely past the pool
    send_request(ACT_FREE, pool0 + 2, COUNT_MAX);     // clipped at the pool end
    send_request(ACT_UNUSED, FRAME_MAX, COUNT_MAX);
    send_request(ACT_FREE, FRAME_MAX, 13'd1);
    send_request(ACT_ALLOC, '0, 13'd99);
    send_request(ACT_ALLOC, '0, 13'd98);
    send_request(ACT_FREE, '0, 13'd4096);
    send_request(ACT_ALLOC, '0, 13'd1);
  endtask

  // register extremes: wrapping frame sums, clipped and empty pools
  task automatic test_config_extremes();
    logic [FRAME_W-1:0] full;
    settle_block();
    apply_config(PBASE_MAX, 13'd4096, FRAME_MAX);
    send_request(ACT_POOL_RESET, '0, '0);
    send_request(ACT_ALLOC, '0, 13'd4096);            // whole pool, frame wraps
    full = last_reply.frame;
    send_request(ACT_ALLOC, '0, 13'd1);
    send_request(ACT_FREE, full, 13'd4096);
    send_request(ACT_ALLOC, '0, 13'd1);
    settle_block();
    apply_config('0, COUNT_MAX, '0);                  // count above pool size
    send_request(ACT_POOL_RESET, '0, '0);
    send_request(ACT_ALLOC, '0, 13'd4096);
    send_request(ACT_FREE, '0, 13'd4096);
    settle_block();
    apply_config(PBASE_W'({$urandom, $urandom}), '0, rand_frame());   // empty pool
    send_request(ACT_POOL_RESET, '0, '0);
    send_request(ACT_ALLOC, '0, 13'd1);
    send_request(ACT_FREE, sh_dmap_base + FRAME_W'(sh_pool_base), 13'd10);
    send_request(ACT_ALLOC, '0, 13'd1);
  endtask

  // output held off for a long stretch while requests keep coming
  task automatic test_output_hold();
    settle_block();
    apply_config(PBASE_W'({$urandom, $urandom}), 13'd4096, rand_frame());
    send_idle_pct = 0;
    recv_idle_pct = 0;
    send_request(ACT_POOL_RESET, '0, '0);
    hold_len = HOLD_LONG;
    repeat (12) send_request(ACT_ALLOC, rand_frame(), 13'($urandom_range(1, 8)));
  endtask

  function automatic logic [COUNT_W-1:0] pick_alloc_count();
    int unsigned r;
    r = $urandom_range(99);
    if (r < 80) return COUNT_W'($urandom_range(1, 16));
    if (r < 96) return COUNT_W'($urandom_range(17, 256));
    return COUNT_W'($urandom_range(257, 8191));
  endfunction

  // mostly allocations and frees of live runs, with stray and broken requests
  task automatic test_random_traffic(input int unsigned s_pct, input int unsigned r_pct);
    int unsigned r;
    int unsigned k;
    logic [COUNT_W-1:0] c;
    logic [FRAME_W-1:0] pool0;
    settle_block();
    send_idle_pct = s_pct;
    recv_idle_pct = r_pct;
    r = $urandom_range(9);
    c = (r == 0) ? 13'd4096 : (r == 1) ? COUNT_MAX :
        (r == 2) ? 13'($urandom_range(1, 63)) : 13'($urandom_range(64, 4096));
    r = $urandom_range(3);
    apply_config((r == 0) ? '0 : (r == 1) ? PBASE_MAX : PBASE_W'({$urandom, $urandom}), c,
                 ($urandom_range(3) == 0) ? FRAME_MAX : rand_frame());
    pool0 = sh_dmap_base + FRAME_W'(sh_pool_base);
    live_frame.delete();
    live_count.delete();
    send_request(ACT_POOL_RESET, rand_frame(), 13'($urandom));
    for (int unsigned i = 0; i < PHASE_ITEMS; i++) begin
      // sender waits for the block to empty now and then
      if (i % 120 == 119) drain_replies();
      r = $urandom_range(99);
      if (r < 45 || (r < 75 && live_frame.size() == 0)) begin
        c = pick_alloc_count();
        send_request(ACT_ALLOC, rand_frame(), c);
        if (last_reply.status == STAT_OK) begin
          live_frame.push_back(last_reply.frame);
          live_count.push_back(c);
        end
      end else if (r < 75) begin
        k = $urandom_range(live_frame.size() - 1);
        c = ($urandom_range(4) == 0) ? 13'($urandom_range(1, live_count[k])) : live_count[k];
        send_request(ACT_FREE, live_frame[k], c);
        live_frame.delete(k);
        live_count.delete(k);
      end else if (r < 83) begin
        send_request(ACT_FREE, rand_frame(), 13'($urandom_range(0, 8191)));
      end else if (r < 88) begin
        // overlapping, double and past-the-end frees near the pool
        send_request(ACT_FREE, pool0 + FRAME_W'($urandom_range(0, 4200)),
                     ($urandom_range(9) == 0) ? 13'($urandom) : 13'($urandom_range(1, 300)));
      end else if (r < 91) begin
        send_request(ACT_FREE, pool0 - FRAME_W'($urandom_range(1, 5000)),
                     13'($urandom_range(1, 64)));
      end else if (r < 94) begin
        send_request($urandom_range(1) ? ACT_ALLOC : ACT_FREE, rand_frame(), '0);
      end else if (r < 97) begin
        send_request(ACT_POOL_RESET, rand_frame(), 13'($urandom));
        live_frame.delete();
        live_count.delete();
      end else begin
        send_request(ACT_UNUSED, rand_frame(), 13'($urandom));
      end
    end
  endtask

  initial begin
    mismatches = 0;
    send_idle_pct = 8;
    recv_idle_pct = 72;
    hold_len = 0;
    sh_pool_base = '0;
    sh_pool_count = '0;
    sh_dmap_base = '0;
    shadow_free = '0;
    repeat (10) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    // covers the clearing pass that follows reset
    settle_block();
    test_directed_basics();
    test_config_extremes();
    test_random_traffic(8, 72);
    test_random_traffic(72, 8);
    test_random_traffic(0, 0);
    test_output_hold();
    settle_block();
    if (mismatches == 0 && page_replies.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
